/* rtl/core/armap_pkg.sv */
// ----------------------------------------------------------------------------
// armap_pkg
// Shared types, constants and helpers for the address region map allocator.
// ----------------------------------------------------------------------------
package armap_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int ALIGN_BITS    = 12;

    localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int ADDR_W  = 32;
    localparam int LEN_W   = 32;
    localparam int FLAGS_W = 8;
    localparam int END_W   = ADDR_W + 1;
    // room for an aligned end past the top of the space plus a length
    localparam int WIN_W   = ADDR_W + 3;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 40;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    localparam logic [WIN_W-1:0] ALIGN_MASK =
        (WIN_W'(1) << ALIGN_BITS) - WIN_W'(1);
    localparam logic [WIN_W-1:0] TOP_OF_SPACE = WIN_W'(1) << ADDR_W;

    typedef enum logic [1:0] {
        OP_PLACE   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_QUERY   = 2'd2,
        OP_FIND    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_FULL     = 2'd2,
        ST_NO_SPACE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_WIN,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic    load_in;
        logic    win_calc;
        logic    step;
        logic    move;
        logic    write_entry;
        logic    clear_entry;
        logic    take_flags;
        logic    out_load;
        t_status out_status;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic full;
        logic len_zero;
        logic hit;
        logic last;
        logic clean_done;
        logic wraps;
        logic out_busy;
    } t_dp_stat;

    function automatic logic [WIN_W-1:0] align_up(input logic [WIN_W-1:0] x);
        return (x + ALIGN_MASK) & ~ALIGN_MASK;
    endfunction

    localparam logic [WIN_W-1:0] FIND_START = align_up(WIN_W'(1));

endpackage

/* rtl/core/armap_dp.sv */
// ----------------------------------------------------------------------------
// armap_dp
// Region table, window registers, single-entry compare unit and result register.
// ----------------------------------------------------------------------------
module armap_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  armap_pkg::t_dp_cmd            i_cmd,
    output armap_pkg::t_dp_stat           o_stat,
    input  armap_pkg::t_op                i_in_op,
    input  logic [armap_pkg::ADDR_W-1:0]  i_in_addr,
    input  logic [armap_pkg::LEN_W-1:0]   i_in_len,
    input  logic [armap_pkg::FLAGS_W-1:0] i_in_flags,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output armap_pkg::t_status            o_out_status,
    output logic [armap_pkg::FLAGS_W-1:0] o_out_found,
    output logic [armap_pkg::ADDR_W-1:0]  o_out_free
);
    import armap_pkg::*;

    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [ADDR_W-1:0]        r_start [TABLE_ENTRIES];
    logic [END_W-1:0]         r_end   [TABLE_ENTRIES];
    logic [FLAGS_W-1:0]       r_flags [TABLE_ENTRIES];

    t_op                r_op;
    logic [LEN_W-1:0]   r_len;
    logic [ADDR_W-1:0]  r_addr;
    logic [FLAGS_W-1:0] r_new_flags;
    logic [WIN_W-1:0]   r_ps;
    logic [WIN_W-1:0]   r_pe;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   r_clean;
    logic [FLAGS_W-1:0] r_found;

    logic               r_out_valid;
    t_status            r_out_status;
    logic [FLAGS_W-1:0] r_out_found;
    logic [ADDR_W-1:0]  r_out_free;

    logic [WIN_W-1:0] c_lo;
    logic [WIN_W-1:0] c_hi;
    logic             meets;
    logic             hit;
    logic             last;
    logic [IDX_W-1:0] idx_next;
    logic [IDX_W-1:0] slot;

    assign c_lo = WIN_W'(r_start[r_idx]);
    assign c_hi = WIN_W'(r_end[r_idx]);

    // window [ps,pe) meets region [lo,hi)
    assign meets = ((c_lo <= r_ps) && (r_ps < c_hi)) || ((r_ps <= c_lo) && (c_lo < r_pe));
    assign hit   = r_valid[r_idx] && meets;
    assign last  = (r_idx == LAST_IDX);
    assign idx_next = last ? '0 : r_idx + IDX_W'(1);

    always_comb begin
        slot = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                slot = IDX_W'(i);
            end
        end
    end

    always_comb begin
        o_stat.op         = r_op;
        o_stat.full       = &r_valid;
        o_stat.len_zero   = (r_len == '0);
        o_stat.hit        = hit;
        o_stat.last       = last;
        o_stat.clean_done = (r_clean == LAST_IDX);
        o_stat.wraps      = (r_ps >= TOP_OF_SPACE) || (r_pe > TOP_OF_SPACE);
        o_stat.out_busy   = r_out_valid && !i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_cmd.write_entry) begin
                r_valid[slot] <= 1'b1;
            end
            if (i_cmd.clear_entry) begin
                r_valid[r_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_entry) begin
            r_start[slot] <= r_addr;
            r_end[slot]   <= r_pe[END_W-1:0];
            r_flags[slot] <= r_new_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op        <= i_in_op;
            r_addr      <= i_in_addr;
            r_len       <= i_in_len;
            r_new_flags <= i_in_flags;
            r_idx       <= '0;
            r_clean     <= '0;
            r_found     <= '0;
            unique case (i_in_op)
                OP_FIND: begin
                    r_ps <= FIND_START;
                    r_pe <= FIND_START;
                end
                OP_PLACE: begin
                    r_ps <= WIN_W'(i_in_addr);
                    r_pe <= WIN_W'(i_in_addr) + WIN_W'(i_in_len);
                end
                OP_RELEASE, OP_QUERY: begin
                    // empty window: meets only a region that holds the address
                    r_ps <= WIN_W'(i_in_addr);
                    r_pe <= WIN_W'(i_in_addr);
                end
            endcase
        end else begin
            if (i_cmd.win_calc) begin
                r_pe <= align_up(r_ps + WIN_W'(r_len));
            end
            if (i_cmd.step) begin
                r_idx   <= idx_next;
                r_clean <= r_clean + IDX_W'(1);
            end
            if (i_cmd.move) begin
                r_ps    <= align_up(c_hi);
                r_idx   <= idx_next;
                r_clean <= '0;
            end
            if (i_cmd.take_flags) begin
                r_found <= r_flags[r_idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_status;
            r_out_found  <= r_found;
            r_out_free   <= (r_op == OP_FIND && i_cmd.out_status == ST_OK) ?
                            r_ps[ADDR_W-1:0] : '0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_found  = r_out_found;
    assign o_out_free   = r_out_free;

endmodule

/* rtl/core/armap_ctrl.sv */
// ----------------------------------------------------------------------------
// armap_ctrl
// Sequencer: walks the table one entry per cycle while scanning and issues datapath commands.
// ----------------------------------------------------------------------------
module armap_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  armap_pkg::t_dp_stat i_stat,
    output armap_pkg::t_dp_cmd  o_cmd
);
    import armap_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_status r_status;
    t_status n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                priority if (i_stat.op == OP_PLACE && i_stat.full) begin
                    n_status = ST_FULL;
                    n_state  = S_DONE;
                end else if (i_stat.op == OP_PLACE && i_stat.len_zero) begin
                    n_status = ST_INVALID;
                    n_state  = S_DONE;
                end else if (i_stat.op == OP_FIND) begin
                    n_state = S_WIN;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_WIN: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.hit) begin
                    unique case (i_stat.op)
                        OP_PLACE: begin
                            n_status = ST_INVALID;
                            n_state  = S_DONE;
                        end
                        OP_RELEASE, OP_QUERY: begin
                            n_status = ST_OK;
                            n_state  = S_DONE;
                        end
                        OP_FIND: begin
                            n_state = S_WIN;
                        end
                    endcase
                end else if (i_stat.op == OP_FIND) begin
                    // a full lap with no hit: the window is settled
                    if (i_stat.clean_done) begin
                        n_status = i_stat.wraps ? ST_NO_SPACE : ST_OK;
                        n_state  = S_DONE;
                    end
                end else if (i_stat.last) begin
                    n_status = (i_stat.op == OP_PLACE) ? ST_OK : ST_INVALID;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            S_START: begin
            end
            S_WIN: begin
                o_cmd.win_calc = 1'b1;
            end
            S_SCAN: begin
                if (i_stat.hit) begin
                    unique case (i_stat.op)
                        OP_PLACE:   o_cmd.out_status = ST_INVALID;
                        OP_RELEASE: o_cmd.clear_entry = 1'b1;
                        OP_QUERY:   o_cmd.take_flags = 1'b1;
                        OP_FIND:    o_cmd.move = 1'b1;
                    endcase
                end else if (i_stat.op == OP_FIND) begin
                    o_cmd.step = !i_stat.clean_done;
                end else if (i_stat.last) begin
                    o_cmd.write_entry = (i_stat.op == OP_PLACE);
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_DONE: begin
                o_cmd.out_load   = !i_stat.out_busy;
                o_cmd.out_status = r_status;
            end
            default: begin
            end
        endcase
    end

endmodule

/* rtl/core/address_region_map_allocator.sv */
// Place, release and query walk the table at most once from accept to result. Find walks
// it once when the first window is free, and once more after each region that pushes the window.
// Throughput: one item at a time; the single-entry compare unit checks one entry per scan cycle.
// A new item is accepted while the previous result still waits in the output register.
// Reset (synchronous, active low) clears all valid bits, the sequencer and the output valid.
// ----------------------------------------------------------------------------
// address_region_map_allocator
// Region table with place, release, flag query and first-fit aligned range search.
// ----------------------------------------------------------------------------
module address_region_map_allocator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // address[31:0], length[63:32], region_flags[71:64]
    input  logic [armap_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // found_flags[7:0], free_address[39:8]
    output logic [armap_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]                       m_axis_tuser
);
    import armap_pkg::*;

    t_dp_cmd            dp_cmd;
    t_dp_stat           dp_stat;
    t_status            out_status;
    logic [FLAGS_W-1:0] out_found;
    logic [ADDR_W-1:0]  out_free;

    armap_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    armap_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_in_op      (t_op'(s_axis_tuser)),
        .i_in_addr    (s_axis_tdata[31:0]),
        .i_in_len     (s_axis_tdata[63:32]),
        .i_in_flags   (s_axis_tdata[71:64]),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_status (out_status),
        .o_out_found  (out_found),
        .o_out_free   (out_free)
    );

    assign m_axis_tdata = {out_free, out_found};
    assign m_axis_tuser = 2'(out_status);

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item accepted while one is in work");

    a_write_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.write_entry |-> !dp_stat.full && !dp_stat.hit)
        else $error("region written into full table or over a stored region");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.out_load |-> !dp_stat.out_busy)
        else $error("result overwrote one not yet taken");

    a_free_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != 2'(ST_OK)) |-> (m_axis_tdata[39:8] == '0))
        else $error("free address nonzero on failed item");

endmodule
